// File: design/bounded_sparse_histogram_defines.svh
// assertion macros for the bounded sparse histogram
`ifndef BOUNDED_SPARSE_HISTOGRAM_DEFINES_SVH
`define BOUNDED_SPARSE_HISTOGRAM_DEFINES_SVH
`ifndef SYNTHESIS
`define BSH_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("bounded_sparse_histogram assertion failed");
`define BSH_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("bounded_sparse_histogram assertion failed");
`else
`define BSH_ASSERT(label, prop)
`define BSH_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: design/bsh_pkg.sv
// types and constants of the bounded sparse histogram
package bsh_pkg;

   localparam int MAX_ENTRIES  = 32;
   localparam int SAMPLE_WIDTH = 16;
   localparam int CFG_W        = 16;
   localparam int CNT_W        = 31;
   localparam int ENTRY_AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int USED_W       = $clog2(MAX_ENTRIES + 1);
   localparam int STATUS_W     = 3;
   localparam int OP_W         = 2;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
   localparam logic [OP_W-1:0] OP_DRAIN = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

   localparam logic [STATUS_W-1:0] ST_COUNTED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NEW_ENTRY   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DROPPED     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_QUERY_REPLY = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DRAIN_ENTRY = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DRAIN_EMPTY = 3'd5;
   localparam logic [STATUS_W-1:0] ST_CLEARED     = 3'd6;

   localparam logic CSR_MIN_VALUE = 1'b0;
   localparam logic CSR_MAX_VALUE = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]                op;
      logic signed [SAMPLE_WIDTH-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]            status;
      logic signed [SAMPLE_WIDTH-1:0] bin_value;
      logic [CNT_W-1:0]               bin_count;
      logic [CNT_W-1:0]               total_samples;
      logic signed [SAMPLE_WIDTH-1:0] smallest_value;
      logic                           table_empty;
      logic [USED_W-1:0]              entries_used;
      logic                           last;
   } rsp_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] value;
      logic [CNT_W-1:0]               count;
   } entry_type;

endpackage

// File: design/bounded_sparse_histogram.sv
// bounded sparse histogram: sorted entry table in a memory under a sequencer
// add scans the entries in order up to a match or a larger entry; a new entry first shifts the larger ones up
// query scans every stored entry; drain reads and emits each entry in turn; clear, empty drain or query emit directly
// one read port and one write port, one item at a time: next taken after its last beat registers
// results sit in an output register, so the next item is accepted while one waits
// reset empties the table, clears the total and sets the configuration to min 1, max 100; entries need no clearing pass
`include "bounded_sparse_histogram_defines.svh"
module bounded_sparse_histogram (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  bsh_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output bsh_pkg::rsp_type             rsp_data,
   input  logic                         csr_write_en,
   input  logic                         csr_index,
   input  logic [bsh_pkg::CFG_W-1:0]    csr_data
);
   import bsh_pkg::*;

   localparam int CMP_W = ((SAMPLE_WIDTH > CFG_W) ? SAMPLE_WIDTH : CFG_W) + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_ADD_RD, S_ADD_CMP, S_SHIFT_RD, S_SHIFT_WR, S_INSERT,
      S_QRY_RD, S_QRY_CMP, S_DR_RD, S_DR_LOAD, S_EMIT
   } state_type;

   state_type                      state_ff, state_in;
   logic [ENTRY_AW-1:0]            idx_ff, idx_in;
   logic [USED_W-1:0]              pos_ff, pos_in;
   logic [USED_W-1:0]              j_ff, j_in;
   logic signed [SAMPLE_WIDTH-1:0] key_ff, key_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   rsp_type                        pend_ff, pend_in;
   logic                           drain_more_ff, drain_more_in;
   logic [USED_W-1:0]              used_ff, used_in;
   logic [CNT_W-1:0]               total_ff, total_in;
   logic signed [SAMPLE_WIDTH-1:0] smallest_ff, smallest_in;
   logic signed [CFG_W-1:0]        min_ff, min_in;
   logic signed [CFG_W-1:0]        max_ff, max_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rsp_type                        rsp_ff, rsp_in;

   entry_type                      mem [MAX_ENTRIES];
   entry_type                      rd_data_ff;
   logic                           rd_en;
   logic [ENTRY_AW-1:0]            rd_addr;
   logic                           wr_en;
   logic [ENTRY_AW-1:0]            wr_addr;
   entry_type                      wr_data;

   logic                           rsp_free;
   logic                           req_accept;
   logic signed [CMP_W-1:0]        s_ext, max_ext, lo_ext, clamp_a, clamp_b;
   logic signed [SAMPLE_WIDTH-1:0] clamped;
   logic                           scan_last;
   logic [USED_W-1:0]              idx_next;
   logic [CNT_W-1:0]               cnt_inc;
   logic [CNT_W-1:0]               total_inc;
   logic signed [SAMPLE_WIDTH-1:0] smallest_new;

   function automatic rsp_type make_rsp(
      input logic [STATUS_W-1:0]            status,
      input logic signed [SAMPLE_WIDTH-1:0] value,
      input logic [CNT_W-1:0]               count,
      input logic [CNT_W-1:0]               total,
      input logic [USED_W-1:0]              used,
      input logic signed [SAMPLE_WIDTH-1:0] smallest,
      input logic                           last
   );
      rsp_type r;
      r.status         = status;
      r.bin_value      = value;
      r.bin_count      = count;
      r.total_samples  = total;
      r.smallest_value = (used == '0) ? {SAMPLE_WIDTH{1'b1}} : smallest;
      r.table_empty    = (used == '0);
      r.entries_used   = used;
      r.last           = last;
      return r;
   endfunction

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // clamp: limit to max, then raise to min - 1; when min - 1 falls below the
   // sample range the sample already exceeds it, so the low part always fits
   assign s_ext   = CMP_W'(req_data.sample);
   assign max_ext = CMP_W'(max_ff);
   assign lo_ext  = CMP_W'(min_ff) - CMP_W'(1);
   assign clamp_a = (s_ext > max_ext) ? max_ext : s_ext;
   assign clamp_b = (clamp_a < lo_ext) ? lo_ext : clamp_a;
   assign clamped = clamp_b[SAMPLE_WIDTH-1:0];

   assign idx_next  = USED_W'(idx_ff) + USED_W'(1);
   assign scan_last = (idx_next == used_ff);
   assign cnt_inc   = (rd_data_ff.count == CNT_MAX) ? CNT_MAX : rd_data_ff.count + CNT_W'(1);
   assign total_inc = (total_ff == CNT_MAX) ? CNT_MAX : total_ff + CNT_W'(1);
   assign smallest_new = (pos_ff == '0) ? key_ff : smallest_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      j_in          = j_ff;
      key_in        = key_ff;
      cnt_in        = cnt_ff;
      pend_in       = pend_ff;
      drain_more_in = drain_more_ff;
      used_in       = used_ff;
      total_in      = total_ff;
      smallest_in   = smallest_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = rd_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_MIN_VALUE: min_in = csr_data;
            CSR_MAX_VALUE: max_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               idx_in        = '0;
               cnt_in        = '0;
               drain_more_in = 1'b0;
               case (req_data.op)
                  OP_ADD: begin
                     key_in = clamped;
                     if (used_ff == '0) begin
                        pos_in   = '0;
                        state_in = S_INSERT;
                     end else begin
                        state_in = S_ADD_RD;
                     end
                  end
                  OP_QUERY: begin
                     key_in = req_data.sample;
                     if (used_ff == '0) begin
                        pend_in  = make_rsp(ST_QUERY_REPLY, req_data.sample, '0, total_ff,
                                            used_ff, smallest_ff, 1'b1);
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_QRY_RD;
                     end
                  end
                  OP_DRAIN: begin
                     if (used_ff == '0) begin
                        pend_in  = make_rsp(ST_DRAIN_EMPTY, '0, '0, '0, '0, smallest_ff, 1'b1);
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_DR_RD;
                     end
                  end
                  default: begin
                     used_in  = '0;
                     total_in = '0;
                     pend_in  = make_rsp(ST_CLEARED, '0, '0, '0, '0, smallest_ff, 1'b1);
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_ADD_RD: begin
            rd_en    = 1'b1;
            state_in = S_ADD_CMP;
         end
         S_ADD_CMP: begin
            if (rd_data_ff.value == key_ff) begin
               wr_en    = 1'b1;
               wr_data  = '{value: key_ff, count: cnt_inc};
               total_in = total_inc;
               pend_in  = make_rsp(ST_COUNTED, key_ff, cnt_inc, total_inc, used_ff,
                                   smallest_ff, 1'b1);
               state_in = S_EMIT;
            end else if (rd_data_ff.value < key_ff && !scan_last) begin
               idx_in   = idx_next[ENTRY_AW-1:0];
               state_in = S_ADD_RD;
            end else if (used_ff == USED_W'(MAX_ENTRIES)) begin
               pend_in  = make_rsp(ST_DROPPED, key_ff, '0, total_ff, used_ff,
                                   smallest_ff, 1'b1);
               state_in = S_EMIT;
            end else begin
               // insert point: after this entry if it is smaller, else at it
               pos_in   = (rd_data_ff.value < key_ff) ? idx_next : USED_W'(idx_ff);
               j_in     = used_ff;
               state_in = (rd_data_ff.value < key_ff) ? S_INSERT : S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = ENTRY_AW'(j_ff - USED_W'(1));
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = j_ff[ENTRY_AW-1:0];
            wr_data  = rd_data_ff;
            j_in     = j_ff - USED_W'(1);
            state_in = (j_ff - USED_W'(1) == pos_ff) ? S_INSERT : S_SHIFT_RD;
         end
         S_INSERT: begin
            wr_en       = 1'b1;
            wr_addr     = pos_ff[ENTRY_AW-1:0];
            wr_data     = '{value: key_ff, count: CNT_W'(1)};
            used_in     = used_ff + USED_W'(1);
            total_in    = total_inc;
            smallest_in = smallest_new;
            pend_in     = make_rsp(ST_NEW_ENTRY, key_ff, CNT_W'(1), total_inc,
                                   used_ff + USED_W'(1), smallest_new, 1'b1);
            state_in    = S_EMIT;
         end
         S_QRY_RD: begin
            rd_en    = 1'b1;
            state_in = S_QRY_CMP;
         end
         S_QRY_CMP: begin
            if (scan_last) begin
               pend_in  = make_rsp(ST_QUERY_REPLY, key_ff,
                                   (rd_data_ff.value == key_ff) ? rd_data_ff.count : cnt_ff,
                                   total_ff, used_ff, smallest_ff, 1'b1);
               state_in = S_EMIT;
            end else begin
               if (rd_data_ff.value == key_ff) begin
                  cnt_in = rd_data_ff.count;
               end
               idx_in   = idx_next[ENTRY_AW-1:0];
               state_in = S_QRY_RD;
            end
         end
         S_DR_RD: begin
            rd_en    = 1'b1;
            state_in = S_DR_LOAD;
         end
         S_DR_LOAD: begin
            pend_in = make_rsp(ST_DRAIN_ENTRY, rd_data_ff.value, rd_data_ff.count, total_ff,
                               used_ff, smallest_ff, scan_last);
            if (scan_last) begin
               used_in       = '0;
               total_in      = '0;
               drain_more_in = 1'b0;
            end else begin
               idx_in        = idx_next[ENTRY_AW-1:0];
               drain_more_in = 1'b1;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               state_in     = drain_more_ff ? S_DR_RD : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         drain_more_ff <= 1'b0;
         used_ff       <= '0;
         total_ff      <= '0;
         min_ff        <= CFG_W'(1);
         max_ff        <= CFG_W'(100);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         drain_more_ff <= drain_more_in;
         used_ff       <= used_in;
         total_ff      <= total_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      j_ff        <= j_in;
      key_ff      <= key_in;
      cnt_ff      <= cnt_in;
      pend_ff     <= pend_in;
      smallest_ff <= smallest_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   `BSH_ASSERT(a_used_bounded, used_ff <= USED_W'(MAX_ENTRIES))
   `BSH_ASSERT(a_write_in_table, wr_en |-> (USED_W'(wr_addr) <= used_ff))
   `BSH_ASSERT(a_empty_flag, rsp_valid_ff |-> (rsp_ff.table_empty == (rsp_ff.entries_used == '0)))
   `BSH_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == S_IDLE && !rsp_valid_ff))

endmodule
